/* rtl/swdh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial wire debug host package
// Shared types, command codes and sequence constants for the transaction engine.
// ----------------------------------------------------------------------------
package swdh_pkg;

	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_READ   = 3'd1;
	localparam logic [2:0] CMD_WRITE  = 3'd2;
	localparam logic [2:0] CMD_RESET  = 3'd3;
	localparam logic [2:0] CMD_SWITCH = 3'd4;

	localparam int unsigned LINE_RESET_CYCLES = 50;

	localparam logic [5:0]  XFER_LAST      = 6'd45;
	localparam logic [5:0]  RESET_LAST     = 6'(LINE_RESET_CYCLES - 1);
	localparam logic [5:0]  SWITCH_LAST    = 6'd15;
	localparam logic [15:0] SWITCH_PATTERN = 16'hE79E;

	localparam logic [5:0] IDX_TURN_HDR = 6'd8;
	localparam logic [5:0] IDX_ACK_END  = 6'd12;
	localparam logic [5:0] IDX_WR_TURN  = 6'd12;
	localparam logic [5:0] IDX_RD_PAR   = 6'd44;
	localparam logic [5:0] IDX_WR_PAR   = 6'd45;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_WRITE  = 5'b00100,
		ST_RESET  = 5'b01000,
		ST_SWITCH = 5'b10000
	} op_state_t;

	typedef struct packed {
		logic        line_sample;
		logic [31:0] write_data;
		logic [1:0]  reg_select;
		logic        port_select;
		logic [2:0]  command;
	} item_t;

	typedef struct packed {
		logic        read_parity;
		logic [31:0] read_value;
		logic [2:0]  ack_code;
		logic        done_res;
		logic        busy_res;
		logic        clock_pulse;
		logic        line_drive;
		logic        line_out;
	} result_t;

endpackage

/* rtl/swdh_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted transaction until the engine core consumes it.
// ----------------------------------------------------------------------------
module swdh_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  swdh_pkg::item_t in_item,
	output logic            valid_s1,
	output swdh_pkg::item_t item_s1,
	input  logic            take_s1
);

	logic in_fire;

	assign in_ready = !valid_s1 || take_s1;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* rtl/swdh_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transaction engine core
// Sequences read, write, line reset and switch operations one wire period per item.
// ----------------------------------------------------------------------------
module swdh_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  swdh_pkg::item_t   item,
	output swdh_pkg::result_t res
);

	swdh_pkg::op_state_t op_q, op_e, op_n;
	logic [5:0]  idx_q, idx_e, idx_n, last;
	logic [7:0]  hdr_q, hdr_e;
	logic [31:0] shift_q, shift_e, shift_n;
	logic        par_q, par_e, par_n;
	logic [2:0]  ack_q, ack_e, ack_n;
	logic [31:0] rword_q, rword_n;
	logic        rpar_q, rpar_n;
	logic        start, rnw, hpar;
	logic [1:0]  ack_pos;

	always_comb begin
		op_e    = op_q;
		idx_e   = idx_q;
		hdr_e   = hdr_q;
		shift_e = shift_q;
		par_e   = par_q;
		ack_e   = ack_q;
		start   = (op_q == swdh_pkg::ST_IDLE) && (item.command == swdh_pkg::CMD_READ ||
			item.command == swdh_pkg::CMD_WRITE || item.command == swdh_pkg::CMD_RESET ||
			item.command == swdh_pkg::CMD_SWITCH);
		rnw     = (item.command == swdh_pkg::CMD_READ);
		hpar    = item.port_select ^ rnw ^ item.reg_select[0] ^ item.reg_select[1];
		if (start) begin
			idx_e = '0;
			par_e = 1'b0;
			priority if (item.command == swdh_pkg::CMD_READ) begin
				op_e = swdh_pkg::ST_READ;
			end else if (item.command == swdh_pkg::CMD_WRITE) begin
				op_e = swdh_pkg::ST_WRITE;
			end else if (item.command == swdh_pkg::CMD_RESET) begin
				op_e = swdh_pkg::ST_RESET;
			end else begin
				op_e = swdh_pkg::ST_SWITCH;
			end
			if (item.command == swdh_pkg::CMD_READ || item.command == swdh_pkg::CMD_WRITE) begin
				hdr_e   = {1'b1, 1'b0, hpar, item.reg_select[1], item.reg_select[0], rnw,
					item.port_select, 1'b1};
				ack_e   = '0;
				shift_e = rnw ? 32'd0 : item.write_data;
			end
		end
	end

	always_comb begin
		res         = '0;
		res.line_drive = 1'b1;
		op_n        = op_e;
		idx_n       = idx_e;
		shift_n     = shift_e;
		par_n       = par_e;
		ack_n       = ack_e;
		rword_n     = rword_q;
		rpar_n      = rpar_q;
		last        = '0;
		ack_pos     = idx_e[1:0] - 2'd1;
		unique case (op_e)
			swdh_pkg::ST_IDLE: begin
				last = '0;
			end
			swdh_pkg::ST_READ, swdh_pkg::ST_WRITE: begin
				last = swdh_pkg::XFER_LAST;
				priority if (idx_e < swdh_pkg::IDX_TURN_HDR) begin
					res.line_out = hdr_e[idx_e[2:0]];
				end else if (idx_e == swdh_pkg::IDX_TURN_HDR) begin
					res.line_drive = 1'b0;
				end else if (idx_e < swdh_pkg::IDX_ACK_END) begin
					res.line_drive = 1'b0;
					ack_n[ack_pos] = ack_e[ack_pos] | item.line_sample;
				end else if (op_e == swdh_pkg::ST_READ) begin
					if (idx_e < swdh_pkg::IDX_RD_PAR) begin
						res.line_drive = 1'b0;
						shift_n = {item.line_sample, shift_e[31:1]};
					end else if (idx_e == swdh_pkg::IDX_RD_PAR) begin
						res.line_drive = 1'b0;
						rword_n = shift_e;
						rpar_n  = item.line_sample;
					end
				end else begin
					if (idx_e > swdh_pkg::IDX_WR_TURN && idx_e < swdh_pkg::IDX_WR_PAR) begin
						res.line_out = shift_e[0];
						shift_n = {1'b0, shift_e[31:1]};
						par_n   = par_e ^ shift_e[0];
					end else if (idx_e == swdh_pkg::IDX_WR_PAR) begin
						res.line_out = par_e;
					end
				end
			end
			swdh_pkg::ST_RESET: begin
				last = swdh_pkg::RESET_LAST;
				res.line_out = 1'b1;
			end
			swdh_pkg::ST_SWITCH: begin
				last = swdh_pkg::SWITCH_LAST;
				res.line_out = swdh_pkg::SWITCH_PATTERN[idx_e[3:0]];
			end
			default: begin
				last = '0;
			end
		endcase
		if (op_e != swdh_pkg::ST_IDLE) begin
			res.clock_pulse = 1'b1;
			if (idx_e >= last) begin
				res.done_res = 1'b1;
				op_n  = swdh_pkg::ST_IDLE;
				idx_n = '0;
			end else begin
				res.busy_res = 1'b1;
				idx_n = idx_e + 6'd1;
			end
		end
		res.ack_code    = ack_n;
		res.read_value  = rword_n;
		res.read_parity = rpar_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= swdh_pkg::ST_IDLE;
			idx_q   <= '0;
			hdr_q   <= '0;
			shift_q <= '0;
			par_q   <= 1'b0;
			ack_q   <= '0;
			rword_q <= '0;
			rpar_q  <= 1'b0;
		end else if (adv) begin
			op_q    <= op_n;
			idx_q   <= idx_n;
			hdr_q   <= hdr_e;
			shift_q <= shift_n;
			par_q   <= par_n;
			ack_q   <= ack_n;
			rword_q <= rword_n;
			rpar_q  <= rpar_n;
		end
	end

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		op_q == swdh_pkg::ST_IDLE |-> idx_q == 6'd0)
		else $error("Index is not zero while idle.");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.done_res |-> !res.busy_res && res.clock_pulse)
		else $error("Final period also reports busy.");

	a_xfer_ends: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (op_q == swdh_pkg::ST_READ || op_q == swdh_pkg::ST_WRITE) &&
		idx_q == swdh_pkg::XFER_LAST |=> op_q == swdh_pkg::ST_IDLE)
		else $error("Transfer did not end after its last period.");

	a_released_low: assert property (@(posedge clk) disable iff (!arst_n)
		!res.line_drive |-> !res.line_out && op_e != swdh_pkg::ST_IDLE)
		else $error("Released line carries a driven level.");

endmodule

/* rtl/swdh_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output buffer
// Output register with a skid entry that takes one result under backpressure; the engine stalls while it is full.
// ----------------------------------------------------------------------------
module swdh_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  swdh_pkg::result_t in_res,
	output logic              out_valid,
	input  logic              out_ready,
	output swdh_pkg::result_t out_res
);

	logic              skid_v_q;
	swdh_pkg::result_t skid_q;
	logic              in_fire;

	assign in_ready = !skid_v_q;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (!out_valid || out_ready) begin
			if (skid_v_q) begin
				out_valid <= 1'b1;
				skid_v_q  <= 1'b0;
			end else begin
				out_valid <= in_fire;
			end
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || out_ready) begin
			if (skid_v_q) begin
				out_res <= skid_q;
			end else if (in_fire) begin
				out_res <= in_res;
			end
		end else if (in_fire) begin
			skid_q <= in_res;
		end
	end

	a_skid_only_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid)
		else $error("Skid entry held without a pending output.");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && out_ready |=> !skid_v_q && out_valid)
		else $error("Skid entry did not move to the output register.");

endmodule

/* rtl/swd_host_transaction_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial wire debug host transaction engine
// Each transaction is one wire clock period: it may start an operation and
// carries the sampled line level; each produces one result transaction.
// ----------------------------------------------------------------------------
//  Channel  Direction  Content
//  s_axis   in         command, port select, register select, write data, sample
//  m_axis   out        line level, drive, clock pulse, status, ack, read word
//
// One transaction per cycle unless m_axis stalls; the result is registered.
// The input register and the core state advance together once per period.
// The output register plus a skid entry absorb a stalled m_axis_tready.
// Reset clears the valid flags and core state; the engine starts idle with zero status.
// ----------------------------------------------------------------------------
module swd_host_transaction_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] command, [3] port_select, [5:4] reg_select, [37:6] write_data,
	// [38] line_sample, [39] zero
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] line_out, [1] line_drive, [2] clock_pulse, [3] busy_res, [4] done_res,
	// [7:5] ack_code, [39:8] read_value, [40] read_parity, [47:41] zero
	output logic [47:0] m_axis_tdata
);

	swdh_pkg::item_t   in_item, item_s1;
	swdh_pkg::result_t core_res, out_res;
	logic              valid_s1, buf_ready, adv;

	assign in_item = s_axis_tdata[38:0];
	assign adv     = valid_s1 && buf_ready;

	swdh_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take_s1  (adv)
	);

	swdh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (core_res)
	);

	swdh_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (buf_ready),
		.in_res    (core_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {7'd0, out_res};

endmodule

/* sim/swd_host_transaction_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial wire debug host transaction engine testbench
// Drives wire periods into the engine, reads, writes, line resets, switch
// sequences and ignored commands, with random stalls on both streams. A
// period-level model of the engine predicts every result transaction, and
// each received result is checked field by field in order.
// ----------------------------------------------------------------------------
module swd_host_transaction_engine_tb;

	localparam logic [2:0] CMD_CODE_MAX = 3'd7;
	localparam int         STALL_LIMIT  = 2000;
	localparam int         ITEM_BUDGET  = 650;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;

	// Engine model state.
	logic [2:0]  eng_op = swdh_pkg::CMD_NONE;
	logic [5:0]  eng_idx = '0;
	logic [31:0] eng_word = '0;
	logic [7:0]  eng_hdr = '0;
	logic [2:0]  eng_ack = '0;
	logic        eng_par = 1'b0;
	logic [31:0] rx_word = '0;
	logic        rx_par = 1'b0;

	swdh_pkg::result_t pending_results[$];
	swdh_pkg::result_t want_r;
	swdh_pkg::result_t got_r;
	int      errors = 0;
	int      items_sent = 0;
	int      stall_cycles = 0;
	bit      calm = 1'b0;

	swd_host_transaction_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic swdh_pkg::result_t advance_engine(input swdh_pkg::item_t it);
		swdh_pkg::result_t r;
		logic [5:0] i;
		logic [5:0] last_idx;
		logic       rnw;
		r = '0;
		r.line_drive = 1'b1;
		if (eng_op == swdh_pkg::CMD_NONE && it.command >= swdh_pkg::CMD_READ &&
				it.command <= swdh_pkg::CMD_SWITCH) begin
			eng_op = it.command;
			eng_idx = '0;
			eng_par = 1'b0;
			if (it.command == swdh_pkg::CMD_READ || it.command == swdh_pkg::CMD_WRITE) begin
				rnw = (it.command == swdh_pkg::CMD_READ);
				eng_hdr = {1'b1, 1'b0, ^{it.port_select, rnw, it.reg_select},
					it.reg_select[1], it.reg_select[0], rnw, it.port_select, 1'b1};
				eng_ack = '0;
				eng_word = (it.command == swdh_pkg::CMD_WRITE) ? it.write_data : 32'd0;
			end
		end
		if (eng_op != swdh_pkg::CMD_NONE) begin
			i = eng_idx;
			r.clock_pulse = 1'b1;
			if (eng_op == swdh_pkg::CMD_READ || eng_op == swdh_pkg::CMD_WRITE) begin
				last_idx = swdh_pkg::XFER_LAST;
				if (i < swdh_pkg::IDX_TURN_HDR) begin
					r.line_out = eng_hdr[i[2:0]];
				end else if (i == swdh_pkg::IDX_TURN_HDR) begin
					r.line_drive = 1'b0;
				end else if (i < swdh_pkg::IDX_ACK_END) begin
					r.line_drive = 1'b0;
					eng_ack[int'(i) - 9] = eng_ack[int'(i) - 9] | it.line_sample;
				end else if (eng_op == swdh_pkg::CMD_READ) begin
					if (i < swdh_pkg::IDX_RD_PAR) begin
						r.line_drive = 1'b0;
						eng_word[int'(i) - 12] = eng_word[int'(i) - 12] | it.line_sample;
					end else if (i == swdh_pkg::IDX_RD_PAR) begin
						r.line_drive = 1'b0;
						rx_word = eng_word;
						rx_par = it.line_sample;
					end
				end else begin
					if (i > swdh_pkg::IDX_WR_TURN && i < swdh_pkg::IDX_WR_PAR) begin
						r.line_out = eng_word[int'(i) - 13];
						eng_par = eng_par ^ r.line_out;
					end else if (i == swdh_pkg::IDX_WR_PAR) begin
						r.line_out = eng_par;
					end
				end
			end else if (eng_op == swdh_pkg::CMD_RESET) begin
				last_idx = swdh_pkg::RESET_LAST;
				r.line_out = 1'b1;
			end else begin
				last_idx = swdh_pkg::SWITCH_LAST;
				r.line_out = swdh_pkg::SWITCH_PATTERN[i[3:0]];
			end
			if (i >= last_idx) begin
				r.done_res = 1'b1;
				eng_op = swdh_pkg::CMD_NONE;
				eng_idx = '0;
			end else begin
				r.busy_res = 1'b1;
				eng_idx = i + 6'd1;
			end
		end
		r.ack_code = eng_ack;
		r.read_value = rx_word;
		r.read_parity = rx_par;
		return r;
	endfunction

	task automatic send_period(input swdh_pkg::item_t it);
		swdh_pkg::result_t r;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 23) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, it};
		do @(posedge clk); while (!s_axis_tready);
		r = advance_engine(it);
		pending_results.push_back(r);
		items_sent++;
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Starts one operation and feeds periods until the engine is idle again.
	// fill selects the sampled line: 0 low, 1 high, 2 random.
	task automatic run_op(input logic [2:0] cmd, input logic port, input logic [1:0] regsel,
			input logic [31:0] wdata, input int fill, input bit noise);
		swdh_pkg::item_t it;
		it.command = cmd;
		it.port_select = port;
		it.reg_select = regsel;
		it.write_data = wdata;
		it.line_sample = (fill == 2) ? 1'($urandom_range(1)) : 1'(fill);
		send_period(it);
		while (eng_op != swdh_pkg::CMD_NONE) begin
			if (noise) begin
				it.command = 3'($urandom_range(CMD_CODE_MAX));
				it.port_select = 1'($urandom_range(1));
				it.reg_select = 2'($urandom_range(3));
				it.write_data = $urandom;
			end else begin
				it.command = swdh_pkg::CMD_NONE;
			end
			it.line_sample = (fill == 2) ? 1'($urandom_range(1)) : 1'(fill);
			send_period(it);
		end
	endtask

	function automatic logic [2:0] pick_operation();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			return swdh_pkg::CMD_READ;
		else if (pick < 70)
			return swdh_pkg::CMD_WRITE;
		else if (pick < 80)
			return swdh_pkg::CMD_RESET;
		return swdh_pkg::CMD_SWITCH;
	endfunction

	task automatic test_idle_and_unknown();
		swdh_pkg::item_t it;
		it.command = swdh_pkg::CMD_NONE;
		it.port_select = 1'b1;
		it.reg_select = 2'b11;
		it.write_data = 32'hFFFF_FFFF;
		it.line_sample = 1'b1;
		send_period(it);
		for (int c = swdh_pkg::CMD_SWITCH + 1; c <= CMD_CODE_MAX; c++) begin
			it.command = 3'(c);
			it.line_sample = ~it.line_sample;
			send_period(it);
		end
	endtask

	task automatic test_read_extremes();
		run_op(swdh_pkg::CMD_READ, 1'b0, 2'b00, 32'd0, 1, 1'b0);
		run_op(swdh_pkg::CMD_READ, 1'b1, 2'b11, 32'hFFFF_FFFF, 0, 1'b0);
	endtask

	task automatic test_write_extremes();
		run_op(swdh_pkg::CMD_WRITE, 1'b1, 2'b10, 32'hFFFF_FFFF, 1, 1'b0);
		run_op(swdh_pkg::CMD_WRITE, 1'b0, 2'b01, 32'd0, 0, 1'b0);
	endtask

	// Line reset and switch leave the ack and read word of the last read alone.
	task automatic test_reset_and_switch();
		run_op(swdh_pkg::CMD_READ, 1'b0, 2'b10, 32'd0, 2, 1'b0);
		run_op(swdh_pkg::CMD_RESET, 1'b1, 2'b11, 32'hFFFF_FFFF, 1, 1'b0);
		run_op(swdh_pkg::CMD_SWITCH, 1'b0, 2'b00, 32'd0, 0, 1'b0);
	endtask

	task automatic test_commands_while_busy();
		run_op(swdh_pkg::CMD_WRITE, 1'b1, 2'b00, $urandom, 2, 1'b1);
		run_op(swdh_pkg::CMD_READ, 1'b0, 2'b11, $urandom, 2, 1'b1);
		run_op(swdh_pkg::CMD_SWITCH, 1'b1, 2'b01, $urandom, 2, 1'b1);
	endtask

	task automatic test_pause_until_drained();
		run_op(swdh_pkg::CMD_READ, 1'b1, 2'b10, $urandom, 2, 1'b0);
		hold_until_drained();
		run_op(swdh_pkg::CMD_WRITE, 1'b0, 2'b11, $urandom, 2, 1'b0);
	endtask

	task automatic test_back_to_back();
		calm = 1'b1;
		for (int n = 0; n < 2; n++)
			run_op(pick_operation(), 1'($urandom_range(1)), 2'($urandom_range(3)),
				$urandom, 2, 1'b1);
		calm = 1'b0;
	endtask

	task automatic test_random();
		swdh_pkg::item_t it;
		while (items_sent < ITEM_BUDGET) begin
			if ($urandom_range(99) < 12) begin
				it.command = ($urandom_range(1) == 0) ? swdh_pkg::CMD_NONE
					: 3'($urandom_range(swdh_pkg::CMD_SWITCH + 1, CMD_CODE_MAX));
				it.port_select = 1'($urandom_range(1));
				it.reg_select = 2'($urandom_range(3));
				it.write_data = $urandom;
				it.line_sample = 1'($urandom_range(1));
				send_period(it);
			end else begin
				run_op(pick_operation(), 1'($urandom_range(1)), 2'($urandom_range(3)),
					$urandom, 2, $urandom_range(3) == 0);
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
			errors++;
		end
	endfunction

	always @(negedge clk) begin
		if (calm)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(99) >= 23);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected transaction, expected none, actual %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want_r = pending_results.pop_front();
				got_r = m_axis_tdata[40:0];
				check_field("line_out", 32'(want_r.line_out), 32'(got_r.line_out));
				check_field("line_drive", 32'(want_r.line_drive), 32'(got_r.line_drive));
				check_field("clock_pulse", 32'(want_r.clock_pulse), 32'(got_r.clock_pulse));
				check_field("busy_res", 32'(want_r.busy_res), 32'(got_r.busy_res));
				check_field("done_res", 32'(want_r.done_res), 32'(got_r.done_res));
				check_field("ack_code", 32'(want_r.ack_code), 32'(got_r.ack_code));
				check_field("read_value", want_r.read_value, got_r.read_value);
				check_field("read_parity", 32'(want_r.read_parity), 32'(got_r.read_parity));
				check_field("padding", 32'd0, 32'(m_axis_tdata[47:41]));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_and_unknown();
		test_read_extremes();
		test_write_extremes();
		test_reset_and_switch();
		test_commands_while_busy();
		test_pause_until_drained();
		test_back_to_back();
		test_random();

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
